// File: rtl/core/pstd_pkg.sv
`timescale 1ns / 1ps
package pstd_pkg;

  // Default sizes for the top-level parameters
  localparam int ADC_BITS_DEF   = 14;
  localparam int INDEX_BITS_DEF = 24;

  // Fixed field widths
  localparam int BASE_W   = 14;
  localparam int THR_W    = 14;
  localparam int WIN_W    = 16;
  localparam int TICK_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ALGO_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEG_POL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 3'd4;

  // Discrimination modes
  localparam logic MODE_ABOVE = 1'b0;
  localparam logic MODE_CROSS = 1'b1;

  // Reset values of the registers
  localparam logic [WIN_W-1:0] WINDOW_RST = 16'd5000;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic             algo_mode;
    logic             negative_polarity;
    logic [BASE_W-1:0] baseline_level;
    logic [THR_W-1:0]  threshold_counts;
    logic [WIN_W-1:0]  window_length;
  } pstd_cfg_t;

  // One queue entry: the one or two triggers caused by a sample
  typedef struct packed {
    logic [TICK_W-1:0] tick0;
    logic [TICK_W-1:0] tick1;
    logic              two;
  } pstd_entry_t;

endpackage

// File: rtl/core/pstd_if.sv
`timescale 1ns / 1ps
interface pstd_sample_if #(
  parameter int ADC_BITS = pstd_pkg::ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;
  logic                end_of_waveform;

  modport source (output valid, output adc_sample, output end_of_waveform, input ready);
  modport sink   (input valid, input adc_sample, input end_of_waveform, output ready);
endinterface

interface pstd_trigger_if;
  logic                      valid;
  logic                      ready;
  logic [pstd_pkg::TICK_W-1:0] trigger_tick;
  logic                      last_of_run;

  modport source (output valid, output trigger_tick, output last_of_run, input ready);
  modport sink   (input valid, input trigger_tick, input last_of_run, output ready);
endinterface

// File: rtl/core/pstd_front.sv
`timescale 1ns / 1ps
module pstd_front
  import pstd_pkg::*;
#(
  parameter int ADC_BITS   = ADC_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  pstd_cfg_t   cfg,
  pstd_sample_if.sink samples,
  input  logic        q_full,
  output logic        q_push,
  output pstd_entry_t q_data
);

  localparam int SW = ((ADC_BITS > BASE_W) ? ADC_BITS : BASE_W) + 2;
  localparam int PW = ((INDEX_BITS > WIN_W) ? INDEX_BITS : WIN_W) + 1;
  localparam int XW = (PW > TICK_W) ? PW : TICK_W;

  logic [INDEX_BITS-1:0] sample_index;
  logic                  region_open;
  logic [INDEX_BITS-1:0] last_extension;
  logic [PW-1:0]         pending_trigger;
  logic                  region_extended;

  logic [INDEX_BITS-1:0] sample_index_next;
  logic                  region_open_next;
  logic [INDEX_BITS-1:0] last_extension_next;
  logic [PW-1:0]         pending_trigger_next;
  logic                  region_extended_next;

  logic signed [SW-1:0] diff, val, thr;
  logic                 ge, gt, eow, accept;
  logic [PW-1:0]        w, i_x, le_x;
  logic                 emit_a, emit_b, emit_c;
  logic [PW-1:0]        tick_a, tick_c, sel0, sel1;
  logic [XW-1:0]        sel0_x, sel1_x;

  assign accept = samples.valid && samples.ready;
  assign samples.ready = !q_full;
  assign eow = samples.end_of_waveform;

  assign diff = $signed(SW'(samples.adc_sample)) - $signed(SW'(cfg.baseline_level));
  assign val  = cfg.negative_polarity ? -diff : diff;
  assign thr  = $signed(SW'(cfg.threshold_counts));
  assign ge   = (val >= thr);
  assign gt   = (val > thr);

  // zero window acts as one sample
  assign w    = (cfg.window_length == '0) ? PW'(1) : PW'(cfg.window_length);
  assign i_x  = PW'(sample_index);
  assign le_x = PW'(last_extension);

  always_comb begin
    logic                  ro;
    logic                  ext;
    logic [INDEX_BITS-1:0] le;
    logic [PW-1:0]         pend;
    ro     = region_open;
    ext    = region_extended;
    le     = last_extension;
    pend   = pending_trigger;
    emit_a = 1'b0;
    emit_b = 1'b0;
    emit_c = 1'b0;
    tick_a = pending_trigger;
    if (cfg.algo_mode == MODE_CROSS) begin
      emit_b = !region_open && ge;
      ro     = ge && !eow;
    end else begin
      // extend, window-spaced trigger, or gap close of the old region
      if (region_open) begin
        if (gt) begin
          le  = sample_index;
          ext = 1'b1;
          if (pending_trigger < i_x) begin
            emit_a = 1'b1;
            pend   = pending_trigger + w;
          end
        end else if (i_x >= le_x + w) begin
          emit_a = region_extended;
          tick_a = le_x;
          ro     = 1'b0;
        end
      end
      // region start
      if (!ro && ge) begin
        ro     = 1'b1;
        ext    = 1'b0;
        le     = sample_index;
        pend   = i_x + w;
        emit_b = 1'b1;
      end
      // end-of-waveform close
      if (eow && ro) begin
        emit_c = ext;
        ro     = 1'b0;
        ext    = 1'b0;
      end
    end
    tick_c               = PW'(le);
    region_open_next     = ro;
    region_extended_next = ext;
    last_extension_next  = le;
    pending_trigger_next = pend;
  end

  always_comb begin
    if (emit_a) begin
      sel0 = tick_a;
    end else if (emit_b) begin
      sel0 = i_x;
    end else begin
      sel0 = tick_c;
    end
    if (emit_a && emit_b) begin
      sel1 = i_x;
    end else begin
      sel1 = tick_c;
    end
  end

  assign sel0_x = XW'(sel0);
  assign sel1_x = XW'(sel1);

  assign q_push       = accept && (emit_a || emit_b || emit_c);
  assign q_data.tick0 = sel0_x[TICK_W-1:0];
  assign q_data.tick1 = sel1_x[TICK_W-1:0];
  assign q_data.two   = (emit_a && emit_b) || (emit_a && emit_c) || (emit_b && emit_c);

  always_comb begin
    if (eow) begin
      sample_index_next = '0;
    end else if (sample_index != {INDEX_BITS{1'b1}}) begin
      sample_index_next = sample_index + INDEX_BITS'(1);
    end else begin
      sample_index_next = sample_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index    <= '0;
      region_open     <= 1'b0;
      last_extension  <= '0;
      pending_trigger <= '0;
      region_extended <= 1'b0;
    end else if (accept) begin
      sample_index    <= sample_index_next;
      region_open     <= region_open_next;
      last_extension  <= last_extension_next;
      pending_trigger <= pending_trigger_next;
      region_extended <= region_extended_next;
    end
  end

endmodule

// File: rtl/core/pstd_queue.sv
`timescale 1ns / 1ps
module pstd_queue
  import pstd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  pstd_entry_t push_data,
  output logic        full,
  input  logic        pop,
  output pstd_entry_t head,
  output logic        empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pstd_entry_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/pstd_back.sv
`timescale 1ns / 1ps
module pstd_back
  import pstd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  pstd_entry_t   q_head,
  output logic          q_pop,
  pstd_trigger_if.source triggers
);

  logic              out_valid;
  logic [TICK_W-1:0] out_tick;
  logic              out_last;
  logic              second;   // next result is the second of a two-trigger entry
  logic              load, take, is_last;

  assign load    = !out_valid || triggers.ready;
  assign take    = load && !q_empty;
  assign is_last = !q_head.two || second;
  assign q_pop   = take && is_last;

  assign triggers.valid        = out_valid;
  assign triggers.trigger_tick = out_tick;
  assign triggers.last_of_run  = out_last;

  always_ff @(posedge clk) begin
    if (take) begin
      out_tick <= second ? q_head.tick1 : q_head.tick0;
      out_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (take) begin
        second <= !is_last;
      end
    end
  end

endmodule

// File: rtl/core/pmt_self_trigger_discriminator.sv
`timescale 1ns / 1ps
// Self-trigger threshold discriminator for one digitizer channel.
// samples (valid/ready): one ADC sample per transaction, end_of_waveform on the
//   last sample of a waveform; it also returns the sample index to zero.
// triggers (valid/ready): trigger sample indices, last_of_run set on the final
//   trigger caused by a given sample. A sample causes zero, one or two triggers.
// cfg_we/cfg_index/cfg_wdata: register writes, applied from the next sample on;
//   indexes beyond the register list are dropped. Write only while idle.
// Throughput: one sample per cycle while the queue is not full. A trigger enters
//   the queue at the edge that takes its sample and moves on to the output register
//   once that register is free, from which it is offered to the receiver.
//   A sample causing two triggers occupies the output register for both of them,
//   since the single output register drains one trigger per cycle while ready is
//   high; the four-entry queue absorbs such bursts, and a steady run of them holds
//   the samples back to the pace at which the output drains.
// Back-pressure: while the receiver holds ready low the queue fills and then
//   samples ready drops; samples with no trigger still pass while space remains.
// Reset (rst, synchronous): registers return to their defaults (above mode,
//   negative polarity, window 5000), region state and sample index clear, the
//   queue and output register empty.
module pmt_self_trigger_discriminator
  import pstd_pkg::*;
#(
  parameter int ADC_BITS   = ADC_BITS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  pstd_sample_if.sink           samples,
  pstd_trigger_if.source        triggers
);

  pstd_cfg_t   cfg;
  logic        q_full, q_push, q_pop, q_empty;
  pstd_entry_t q_data, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.algo_mode         <= MODE_ABOVE;
      cfg.negative_polarity <= 1'b1;
      cfg.baseline_level    <= '0;
      cfg.threshold_counts  <= '0;
      cfg.window_length     <= WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALGO_MODE:  cfg.algo_mode         <= cfg_wdata[0];
        REG_NEG_POL:    cfg.negative_polarity <= cfg_wdata[0];
        REG_BASELINE:   cfg.baseline_level    <= cfg_wdata[BASE_W-1:0];
        REG_THRESHOLD:  cfg.threshold_counts  <= cfg_wdata[THR_W-1:0];
        REG_WINDOW:     cfg.window_length     <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // front: discrimination, region tracking, trigger selection
  pstd_front #(
    .ADC_BITS   (ADC_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .samples (samples),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  // decouples the sample side from the trigger side
  pstd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // back: splits entries into single triggers, holds the output register
  pstd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .triggers (triggers)
  );

endmodule

// File: tb/sv/pmt_self_trigger_discriminator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the PMT self-trigger discriminator.
// Samples go in through a queue-fed driver; triggers come out to a monitor that
// compares each transaction against a bit-true software copy of the block.
module pmt_self_trigger_discriminator_tb;
  import pstd_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int QUIET_LIMIT   = 2000;  // cycles with no transaction on either side
  localparam int SETTLE_CYCLES = 4;     // settle margin once the block looks idle
  localparam int HOLD_CYCLES   = 90;    // long receiver hold-off, well past queue depth
  localparam int RANDOM_PHASES = 24;
  localparam int PHASE_SAMPLES = 80;
  localparam int MAX_REPORTS   = 10;
  localparam int ADC_MAX       = (1 << ADC_BITS_DEF) - 1;

  // Indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam logic [INDEX_BITS_DEF-1:0] INDEX_SAT = '1;

  typedef struct packed {
    logic [ADC_BITS_DEF-1:0] adc;
    logic                    eow;
  } sample_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic              last;
  } trigger_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pstd_sample_if #(.ADC_BITS(ADC_BITS_DEF)) smp_if ();
  pstd_trigger_if trg_if ();

  pmt_self_trigger_discriminator #(
    .ADC_BITS  (ADC_BITS_DEF),
    .INDEX_BITS(INDEX_BITS_DEF)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .samples  (smp_if),
    .triggers (trg_if)
  );

  // ---------------------------------------------------------------------------
  // Discriminator copy: register shadow and region state, at reset values.
  // Index math is done 40 bits wide so the spaced trigger and the window end
  // never wrap, even near a saturated sample index.
  // ---------------------------------------------------------------------------
  logic                      mode_m     = MODE_ABOVE;
  logic                      negpol_m   = 1'b1;
  logic [BASE_W-1:0]         base_m     = '0;
  logic [THR_W-1:0]          thr_m      = '0;
  logic [WIN_W-1:0]          win_m      = WINDOW_RST;
  logic [INDEX_BITS_DEF-1:0] index_m    = '0;
  logic                      open_m     = 1'b0;
  logic                      extended_m = 1'b0;
  logic [39:0]               last_ext_m = '0;
  logic [39:0]               spaced_m   = '0;

  sample_t  pending_samples[$];    // waiting for the driver
  trigger_t expected_triggers[$];  // waiting for the monitor

  int samples_queued   = 0;
  int samples_taken    = 0;
  int triggers_seen    = 0;
  int triggers_due     = 0;
  int fail_count       = 0;
  int reg_writes       = 0;
  int waveforms        = 0;
  int double_hits      = 0;
  int hold_offs        = 0;
  int quiet_cycles     = 0;
  int hold_left        = 0;
  int send_idle_pct    = 0;
  int recv_idle_pct    = 0;
  int wave_left        = 0;
  bit sample_took      = 1'b0;
  sample_t drv_sample;
  trigger_t got_trigger;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t ERROR: %s", $time, msg);
    end
  endtask

  // Works out the triggers one accepted sample causes and queues them in order:
  // spaced or closing trigger of the old region, new region start, end close.
  task automatic discriminate(input logic [ADC_BITS_DEF-1:0] adc, input logic eow);
    logic [39:0]       i;
    logic [39:0]       w;
    int                sval;
    int                bval;
    int                val;
    int                thr;
    logic [TICK_W-1:0] hits[$];
    trigger_t          entry;
    i = 40'(index_m);
    w = (win_m == '0) ? 40'd1 : 40'(win_m);  // zero window acts as one
    sval = adc;
    bval = base_m;
    val = negpol_m ? bval - sval : sval - bval;
    thr = thr_m;

    if (mode_m == MODE_CROSS) begin
      // region_open doubles as the "currently above" flag here
      if (!open_m && val >= thr) begin
        open_m = 1'b1;
        hits.insert(hits.size(), i[TICK_W-1:0]);
      end else if (open_m && val < thr) begin
        open_m = 1'b0;
      end
      if (eow) open_m = 1'b0;
    end else begin
      if (open_m) begin
        if (val > thr) begin
          last_ext_m = i;
          extended_m = 1'b1;
          // at most one spaced trigger per sample, any others due wait for later extending samples
          if (spaced_m < i) begin
            hits.insert(hits.size(), spaced_m[TICK_W-1:0]);
            spaced_m = spaced_m + w;
          end
        end else if (i >= last_ext_m + w) begin
          if (extended_m) hits.insert(hits.size(), last_ext_m[TICK_W-1:0]);
          open_m = 1'b0;
        end
      end
      // reaching the threshold exactly opens a region but does not extend it
      if (!open_m && val >= thr) begin
        open_m = 1'b1;
        extended_m = 1'b0;
        last_ext_m = i;
        spaced_m = i + w;
        hits.insert(hits.size(), i[TICK_W-1:0]);
      end
      if (eow && open_m) begin
        if (extended_m) hits.insert(hits.size(), last_ext_m[TICK_W-1:0]);
        open_m = 1'b0;
        extended_m = 1'b0;
      end
    end

    // index saturates on very long waveforms, end of waveform restarts it
    if (eow) begin
      index_m = '0;
      waveforms++;
    end else if (index_m != INDEX_SAT) begin
      index_m = index_m + 1'b1;
    end

    if (hits.size() > 1) double_hits++;
    foreach (hits[k]) begin
      entry.tick = hits[k];
      entry.last = (k == hits.size() - 1);
      expected_triggers.insert(expected_triggers.size(), entry);
      triggers_due++;
    end
  endtask

  // Register write: one cycle of cfg_we per call, shadow updated alongside.
  // The shadow applies the same masking the hardware does.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    reg_writes++;
    case (idx)
      REG_ALGO_MODE: mode_m   = data[0];
      REG_NEG_POL:   negpol_m = data[0];
      REG_BASELINE:  base_m   = data[BASE_W-1:0];
      REG_THRESHOLD: thr_m    = data[THR_W-1:0];
      REG_WINDOW:    win_m    = data[WIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_sample(input logic [ADC_BITS_DEF-1:0] adc, input logic eow);
    sample_t s;
    s.adc = adc;
    s.eow = eow;
    pending_samples.insert(pending_samples.size(), s);
    samples_queued++;
  endtask

  // Block is idle once every sample is taken and every trigger has come out;
  // samples that cause nothing may still sit in the pipe, so settle after.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || samples_taken != samples_queued ||
           expected_triggers.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sample side. Acceptance is seen at the rising edge, where the copy of the
  // block is stepped; the driver updates the bus at the falling edge and keeps
  // a transaction on the bus until it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && smp_if.valid && smp_if.ready) begin
      discriminate(smp_if.adc_sample, smp_if.end_of_waveform);
      samples_taken++;
      sample_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      smp_if.valid <= 1'b0;
    end else if (!smp_if.valid || sample_took) begin
      sample_took = 1'b0;
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_sample = pending_samples.pop_front();
        smp_if.valid           <= 1'b1;
        smp_if.adc_sample      <= drv_sample.adc;
        smp_if.end_of_waveform <= drv_sample.eow;
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Trigger side. Ready is randomized per cycle, or forced low while a
  // hold-off is running so the internal queue fills and stalls the samples.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      trg_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      trg_if.ready <= 1'b0;
      hold_left--;
    end else begin
      trg_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && trg_if.valid && trg_if.ready) begin
      triggers_seen++;
      if (expected_triggers.size() == 0) begin
        report($sformatf("trigger with nothing expected: tick %0d last %0b",
                         trg_if.trigger_tick, trg_if.last_of_run));
      end else begin
        got_trigger = expected_triggers.pop_front();
        if (got_trigger.tick !== trg_if.trigger_tick ||
            got_trigger.last !== trg_if.last_of_run) begin
          report($sformatf("trigger %0d: expected tick %0d last %0b, got tick %0d last %0b",
                           triggers_seen, got_trigger.tick, got_trigger.last,
                           trg_if.trigger_tick, trg_if.last_of_run));
        end
      end
    end
  end

  // Watchdog: any transaction on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (smp_if.valid && smp_if.ready) || (trg_if.valid && trg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ERROR: no transaction for %0d cycles, %0d triggers still due",
                 $time, QUIET_LIMIT, expected_triggers.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                    p;
    int                    k;
    int                    amp;
    int                    pulse_len;
    int                    v;
    int                    lvl;
    int                    wcap;
    bit                    pressure;
    logic [CFG_DATA_W-1:0] wd;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    smp_if.valid = 1'b0;
    smp_if.adc_sample = '0;
    smp_if.end_of_waveform = 1'b0;
    trg_if.ready = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 72;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Above mode, window 3: open on equality, extensions, close by gap timeout at
    // a sample that reopens at once (two triggers), full-scale samples with one
    // spaced trigger, then a close at end of waveform.
    set_reg(REG_ALGO_MODE, MODE_ABOVE);
    set_reg(REG_NEG_POL, 16'd0);
    set_reg(REG_BASELINE, 16'd100);
    set_reg(REG_THRESHOLD, 16'd50);
    set_reg(REG_WINDOW, 16'd3);
    set_reg(REG_UNUSED_LO, 16'hFFFF);
    cfg_done();
    push_sample(14'd100, 1'b0);
    push_sample(14'd150, 1'b0);
    push_sample(14'd160, 1'b0);
    push_sample(14'd100, 1'b0);
    push_sample(14'd100, 1'b0);
    push_sample(14'd150, 1'b0);
    repeat (4) push_sample(14'h3FFF, 1'b0);
    push_sample(14'h3FFF, 1'b1);
    wait_idle();

    // Crossing mode at the extremes: baseline and threshold at full scale,
    // negative polarity, so only a zero sample crosses. Window 0 here too.
    set_reg(REG_ALGO_MODE, MODE_CROSS);
    set_reg(REG_NEG_POL, 16'd1);
    set_reg(REG_BASELINE, 16'h3FFF);
    set_reg(REG_THRESHOLD, 16'h3FFF);
    set_reg(REG_WINDOW, 16'd0);
    cfg_done();
    push_sample(14'd0, 1'b0);
    push_sample(14'd0, 1'b0);
    push_sample(14'h3FFF, 1'b0);
    push_sample(14'd0, 1'b0);
    push_sample(14'd0, 1'b1);
    wait_idle();

    // Above mode with the zero window kept: it behaves as a window of one,
    // spaced triggers every sample, then close and reopen back to back.
    set_reg(REG_ALGO_MODE, MODE_ABOVE);
    set_reg(REG_NEG_POL, 16'd0);
    set_reg(REG_BASELINE, 16'd0);
    set_reg(REG_THRESHOLD, 16'd0);
    set_reg(REG_UNUSED_HI, 16'd0);
    cfg_done();
    push_sample(14'd0, 1'b0);
    repeat (3) push_sample(14'd5, 1'b0);
    push_sample(14'd0, 1'b0);
    push_sample(14'd0, 1'b1);
    wait_idle();

    // Random phases: new settings each time, then pulse-shaped waveforms around
    // the threshold. A waveform may run across a phase, so settings also change
    // in mid-waveform. Idling: sender light/receiver heavy, then swapped, then none.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 28;
      end else if (p == 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pressure = (p % 8 == 5);

      // crossing mode with frequent pulses keeps triggers coming during a hold-off
      wd = 16'($urandom);
      wd[0] = (pressure || $urandom_range(9) < 3) ? MODE_CROSS : MODE_ABOVE;
      set_reg(REG_ALGO_MODE, wd);
      if (p == 0 || $urandom_range(3) != 0) set_reg(REG_NEG_POL, 16'($urandom));
      if (p == 0 || pressure || $urandom_range(3) != 0) begin
        wd = 16'($urandom);
        case ($urandom_range(4))
          0: wd[BASE_W-1:0] = '0;
          1: wd[BASE_W-1:0] = '1;
          2: wd[BASE_W-1:0] = 14'd8192;
          default: ;
        endcase
        if (pressure) wd[BASE_W-1:0] = 14'd8192;
        set_reg(REG_BASELINE, wd);
      end
      if (p == 0 || pressure || $urandom_range(3) != 0) begin
        wd = 16'($urandom);
        case ($urandom_range(5))
          0: wd[THR_W-1:0] = '0;
          1: wd[THR_W-1:0] = '1;
          2: ;
          default: wd[THR_W-1:0] = 14'($urandom_range(1, 600));
        endcase
        if (pressure) wd[THR_W-1:0] = 14'($urandom_range(1, 600));
        set_reg(REG_THRESHOLD, wd);
      end
      if (p <= 1 || $urandom_range(3) != 0) begin
        case ($urandom_range(7))
          0: wd = 16'd0;
          1: wd = 16'hFFFF;
          2: wd = WINDOW_RST;
          default: wd = 16'($urandom_range(1, 10));
        endcase
        if (p == 1) wd = 16'hFFFF;
        set_reg(REG_WINDOW, wd);
      end
      if ($urandom_range(3) == 0) begin
        set_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 16'($urandom));
      end
      cfg_done();

      // Pulses: amplitude at, just over, well over or under the threshold,
      // lasting up to a few windows; baseline noise in between and the odd
      // full-range sample. Waveform lengths vary, short mostly.
      pulse_len = 0;
      amp = 0;
      for (k = 0; k < PHASE_SAMPLES; k++) begin
        wcap = (win_m == '0) ? 1 : ((win_m > 12) ? 12 : int'(win_m));
        if (pulse_len == 0 && $urandom_range(5) == 0) begin
          pulse_len = $urandom_range(1, 3 * wcap + 2);
          case ($urandom_range(3))
            0: amp = thr_m;
            1: amp = thr_m + 1;
            2: amp = thr_m + $urandom_range(1, 400);
            default: amp = $urandom_range(0, thr_m);
          endcase
        end
        if (pulse_len > 0) begin
          pulse_len--;
          v = ($urandom_range(3) == 0) ? amp + $urandom_range(0, 2) - 1 : amp;
        end else begin
          v = thr_m - 1 - $urandom_range(0, 40);
        end
        lvl = negpol_m ? int'(base_m) - v : int'(base_m) + v;
        if ($urandom_range(11) == 0) lvl = $urandom_range(0, ADC_MAX);
        if (lvl < 0) lvl = 0;
        else if (lvl > ADC_MAX) lvl = ADC_MAX;
        if (wave_left == 0) wave_left = $urandom_range(4, 70);
        wave_left--;
        push_sample(lvl[ADC_BITS_DEF-1:0], wave_left == 0);
      end

      // receiver goes quiet while the sender keeps offering samples
      if (pressure) begin
        hold_left = HOLD_CYCLES;
        hold_offs++;
      end
      wait_idle();
    end

    if (expected_triggers.size() != 0) begin
      report($sformatf("%0d expected triggers never came out", expected_triggers.size()));
    end

    $display("Run covered %0d samples in %0d complete waveforms, %0d register writes,",
             samples_taken, waveforms, reg_writes);
    $display("  %0d of %0d triggers checked, %0d two-trigger samples, %0d receiver hold-offs.",
             triggers_seen, triggers_due, double_hits, hold_offs);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
